// ===== rtl/core/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

   // Default table depth and header size.
   localparam int MAX_BLOCKS_DEF   = 16;
   localparam int HEADER_BYTES_DEF = 16;

   // Heap span and fixed field widths.
   localparam int               ADDR_W    = 16;
   localparam int               LIMIT_W   = 17;
   localparam logic [16:0]      HEAP_SPAN = 17'h10000;

   // Request opcodes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_REUSED   = 3'd0,
      ST_APPENDED = 3'd1,
      ST_RELEASED = 3'd2,
      ST_MARKED   = 3'd3,
      ST_ZERO_REQ = 3'd4,
      ST_NO_SPACE = 3'd5,
      ST_UNKNOWN  = 3'd6
   } status_type;

   // One block table entry: header address, payload size and free flag.
   typedef struct packed {
      logic              free;
      logic [ADDR_W-1:0] size;
      logic [ADDR_W-1:0] start;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/ffba_table.sv =====
// Block table memory with one write port and one registered read port.
`default_nettype none

module ffba_table #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
   localparam int IDX_W     = $clog2(MAX_BLOCKS)
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire [IDX_W-1:0]       wr_idx,
   input  ffba_pkg::entry_type   wr_data,
   input  wire [IDX_W-1:0]       rd_idx,
   output ffba_pkg::entry_type   rd_data
);

   ffba_pkg::entry_type mem [MAX_BLOCKS];
   ffba_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // Read port, data registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ffba_ctrl.sv =====
// Sequencer that walks the block table one entry a cycle and applies the update.
`default_nettype none

module ffba_ctrl #(
   parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
   localparam int IDX_W       = $clog2(MAX_BLOCKS),
   localparam int CNT_W       = $clog2(MAX_BLOCKS + 1)
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire                   req_opcode,
   input  wire [15:0]            req_request_size,
   input  wire [15:0]            req_block_address,
   input  wire [16:0]            heap_limit,
   output logic [IDX_W-1:0]      tbl_rd_idx,
   input  ffba_pkg::entry_type   tbl_rd_data,
   output logic                  tbl_wr_en,
   output logic [IDX_W-1:0]      tbl_wr_idx,
   output ffba_pkg::entry_type   tbl_wr_data,
   output logic                  rsp_strobe,
   output logic [2:0]            rsp_status,
   output logic [15:0]           rsp_data_address,
   output logic [15:0]           rsp_block_size
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_UPDATE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [16:0]           top_ff, top_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   ffba_pkg::entry_type   hit_ent_ff, hit_ent_in;
   logic                  op_ff, op_in;
   logic [15:0]           size_ff, size_in;
   logic [15:0]           addr_ff, addr_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   ffba_pkg::status_type  rsp_st_ff, rsp_st_in;
   logic [15:0]           rsp_addr_ff, rsp_addr_in;
   logic [15:0]           rsp_size_ff, rsp_size_in;

   logic                  accept;
   logic                  issue_vld;
   logic                  match;
   logic [16:0]           limit_c;
   logic [17:0]           append_sum;
   logic                  fits;
   logic                  is_last;
   logic [15:0]           hit_data_addr;

   assign accept     = start && (state_ff == S_IDLE);
   assign busy       = (state_ff != S_IDLE);
   assign issue_vld  = (scan_ff < cnt_ff);
   assign tbl_rd_idx = scan_ff[IDX_W-1:0];

   // Shared compare unit: fit test for allocate, address test for free.
   always_comb begin
      if (op_ff == ffba_pkg::OP_ALLOC) begin
         match = tbl_rd_data.free && (tbl_rd_data.size >= size_ff);
      end else begin
         match = (({1'b0, tbl_rd_data.start} + 17'(HEADER_BYTES)) == {1'b0, addr_ff});
      end
   end

   // Append check against the clamped heap limit and the table depth.
   assign limit_c    = (heap_limit > ffba_pkg::HEAP_SPAN) ? ffba_pkg::HEAP_SPAN : heap_limit;
   assign append_sum = {1'b0, top_ff} + 18'(HEADER_BYTES) + {2'b00, size_ff};
   assign fits       = (cnt_ff < CNT_W'(MAX_BLOCKS)) && (append_sum <= {1'b0, limit_c});
   assign is_last    = ((CNT_W'(hit_idx_ff) + CNT_W'(1)) == cnt_ff);
   assign hit_data_addr = 16'(hit_ent_ff.start + 16'(HEADER_BYTES));

   // Sequencer next state and datapath.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      top_in      = top_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_ent_in  = hit_ent_ff;
      op_in       = op_ff;
      size_in     = size_ff;
      addr_in     = addr_ff;
      rsp_vld_in  = 1'b0;
      rsp_st_in   = rsp_st_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_size_in = rsp_size_ff;
      tbl_wr_en   = 1'b0;
      tbl_wr_idx  = hit_idx_ff;
      tbl_wr_data = hit_ent_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_opcode;
               size_in = req_request_size;
               addr_in = req_block_address;
               scan_in = '0;
               pend_in = 1'b0;
               hit_in  = 1'b0;
               // A zero-size allocate or a free of address zero is answered without a table walk.
               if (req_opcode == ffba_pkg::OP_ALLOC && req_request_size == 16'd0) begin
                  rsp_vld_in  = 1'b1;
                  rsp_st_in   = ffba_pkg::ST_ZERO_REQ;
                  rsp_addr_in = '0;
                  rsp_size_in = '0;
               end else if (req_opcode == ffba_pkg::OP_FREE &&
                            req_block_address == 16'd0) begin
                  rsp_vld_in  = 1'b1;
                  rsp_st_in   = ffba_pkg::ST_UNKNOWN;
                  rsp_addr_in = '0;
                  rsp_size_in = '0;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Reads are issued one entry ahead of the compare.
            pend_in     = issue_vld;
            pend_idx_in = scan_ff[IDX_W-1:0];
            if (issue_vld) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (pend_ff && match) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_idx_ff;
               hit_ent_in = tbl_rd_data;
               state_in   = S_UPDATE;
            end else if (!issue_vld) begin
               hit_in   = 1'b0;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            rsp_vld_in = 1'b1;
            state_in   = S_IDLE;
            if (op_ff == ffba_pkg::OP_ALLOC) begin
               if (hit_ff) begin
                  // Reuse the first fitting free block.
                  tbl_wr_en        = 1'b1;
                  tbl_wr_data.free = 1'b0;
                  rsp_st_in        = ffba_pkg::ST_REUSED;
                  rsp_addr_in      = hit_data_addr;
                  rsp_size_in      = hit_ent_ff.size;
               end else if (fits) begin
                  // Append a new block at the heap top.
                  tbl_wr_en         = 1'b1;
                  tbl_wr_idx        = cnt_ff[IDX_W-1:0];
                  tbl_wr_data.free  = 1'b0;
                  tbl_wr_data.size  = size_ff;
                  tbl_wr_data.start = top_ff[15:0];
                  cnt_in            = cnt_ff + CNT_W'(1);
                  top_in            = append_sum[16:0];
                  rsp_st_in         = ffba_pkg::ST_APPENDED;
                  rsp_addr_in       = 16'(top_ff[15:0] + 16'(HEADER_BYTES));
                  rsp_size_in       = size_ff;
               end else begin
                  rsp_st_in   = ffba_pkg::ST_NO_SPACE;
                  rsp_addr_in = '0;
                  rsp_size_in = '0;
               end
            end else begin
               if (hit_ff && is_last) begin
                  // The last block goes and the top retreats.
                  cnt_in      = CNT_W'(hit_idx_ff);
                  top_in      = {1'b0, hit_ent_ff.start};
                  rsp_st_in   = ffba_pkg::ST_RELEASED;
                  rsp_addr_in = '0;
                  rsp_size_in = hit_ent_ff.size;
               end else if (hit_ff) begin
                  tbl_wr_en        = 1'b1;
                  tbl_wr_data.free = 1'b1;
                  rsp_st_in        = ffba_pkg::ST_MARKED;
                  rsp_addr_in      = '0;
                  rsp_size_in      = hit_ent_ff.size;
               end else begin
                  rsp_st_in   = ffba_pkg::ST_UNKNOWN;
                  rsp_addr_in = '0;
                  rsp_size_in = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         top_ff     <= '0;
         scan_ff    <= '0;
         pend_ff    <= 1'b0;
         hit_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         top_ff     <= top_in;
         scan_ff    <= scan_in;
         pend_ff    <= pend_in;
         hit_ff     <= hit_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ent_ff  <= hit_ent_in;
      op_ff       <= op_in;
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_size_ff <= rsp_size_in;
   end

   assign rsp_strobe       = rsp_vld_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_data_address = rsp_addr_ff;
   assign rsp_block_size   = rsp_size_ff;

   // The table never holds more entries than its depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count above table depth");

   // An empty table means an empty heap.
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (top_ff == '0))
      else $error("heap top nonzero with empty table");

   // Every update step gives a result word in the next cycle.
   a_update_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |=> rsp_vld_ff)
      else $error("update without result word");

   // An append grows the table by exactly one entry.
   a_append_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_st_ff == ffba_pkg::ST_APPENDED && $past(state_ff) == S_UPDATE)
      |-> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("append did not grow the table");

   // Only granted blocks carry a data address.
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_st_ff != ffba_pkg::ST_REUSED && rsp_st_ff != ffba_pkg::ST_APPENDED)
      |-> (rsp_addr_ff == '0))
      else $error("data address on a non-grant result");

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_block_allocator_core.sv =====
// Top level of the first-fit block allocator: limit register, sequencer and block table.
// The result strobe follows a walk of the table that stops at the first hit or after all
// entries, and then the update step; a zero-size allocate or a free of address zero skips
// the walk, and its strobe rises in the cycle after the accept.
// Throughput: one word at a time; busy falls as the strobe rises, set by the walk of one entry
// per cycle through the single table read port. The receiver cannot stall results.
// Reset (synchronous, active high) empties the table, clears the heap top and sets the limit.
`default_nettype none

module first_fit_block_allocator_core #(
   parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
   localparam int IDX_W       = $clog2(MAX_BLOCKS)
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire         req_opcode,
   input  wire [15:0]  req_request_size,
   input  wire [15:0]  req_block_address,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_data_address,
   output logic [15:0] rsp_block_size,
   input  wire         csr_wr_en,
   input  wire [16:0]  csr_wr_data
);

   logic [16:0]          heap_limit_ff;
   logic [IDX_W-1:0]     tbl_rd_idx;
   ffba_pkg::entry_type  tbl_rd_data;
   logic                 tbl_wr_en;
   logic [IDX_W-1:0]     tbl_wr_idx;
   ffba_pkg::entry_type  tbl_wr_data;

   // Heap limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= ffba_pkg::HEAP_SPAN;
      end else if (csr_wr_en) begin
         heap_limit_ff <= csr_wr_data;
      end
   end

   ffba_ctrl #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_request_size  (req_request_size),
      .req_block_address (req_block_address),
      .heap_limit        (heap_limit_ff),
      .tbl_rd_idx        (tbl_rd_idx),
      .tbl_rd_data       (tbl_rd_data),
      .tbl_wr_en         (tbl_wr_en),
      .tbl_wr_idx        (tbl_wr_idx),
      .tbl_wr_data       (tbl_wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_data_address  (rsp_data_address),
      .rsp_block_size    (rsp_block_size)
   );

   ffba_table #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_idx  (tbl_wr_idx),
      .wr_data (tbl_wr_data),
      .rd_idx  (tbl_rd_idx),
      .rd_data (tbl_rd_data)
   );

endmodule

`default_nettype wire
